>>> sv/pir_pkg.sv
// Shared types, constants and byte rules for the PCI-to-ISA interrupt router.
package pir_pkg;

  localparam int unsigned LANES       = 4;
  localparam int unsigned LANE_W      = 2;
  localparam int unsigned ROWS        = 64;
  localparam int unsigned ROW_W       = 6;
  localparam int unsigned ROUTE_COUNT = 4;
  localparam int unsigned ROUTE_W     = 2;
  localparam int unsigned IRQ_W       = 4;
  localparam int unsigned SHARE_W     = ROUTE_W + IRQ_W;
  localparam int unsigned SLOT_BIAS   = 2;

  localparam logic [7:0]  ROUTE_BASE   = 8'h60;
  localparam logic [15:0] IRQ_ALLOWED  = 16'hdef8;
  localparam logic [7:0]  ROUTE_OFF    = 8'h80;
  localparam logic [7:0]  ROUTE_MASK   = 8'h8f;
  localparam logic [7:0]  TIMER_MASK   = 8'hd7;
  localparam logic [7:0]  STAT_W1C     = 8'h78;
  localparam logic [7:0]  STAT_FIXED   = 8'h02;
  localparam logic [7:0]  CMD_KEEP     = 8'h08;
  localparam logic [7:0]  CMD_FIXED    = 8'h07;
  localparam logic [7:0]  BIT0_MASK    = 8'h01;
  localparam logic [11:0] PROT_LO      = 12'h010;
  localparam logic [11:0] PROT_HI      = 12'h034;
  localparam logic [12:0] LAST_BYTE    = 13'h0ff;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_LEVEL = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_RAISE = 2'd1,
    ACT_LOWER = 2'd2
  } act_e;

  typedef struct packed {
    logic capture;   // take the input beat, start store reads
    logic share_rd;  // read the sharing word picked by the route byte
    logic commit;    // update the stores and load the result register
  } cmd_t;

  function automatic logic [7:0] cfg_default(input logic [7:0] a);
    logic [7:0] v;
    unique case (a) inside
      8'h04:                  v = 8'h07;
      8'h07:                  v = 8'h02;
      8'h4c:                  v = 8'h4d;
      8'h4e:                  v = 8'h03;
      [8'h60:8'h63], 8'h70:   v = 8'h80;
      8'h69, 8'h78:           v = 8'h02;
      8'h76, 8'h77:           v = 8'h0c;
      8'ha0:                  v = 8'h08;
      8'ha8:                  v = 8'h0f;
      default:                v = 8'h00;
    endcase
    return v;
  endfunction

  // {write enable, stored value} for one byte written at offset a
  function automatic logic [8:0] store_rule(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] old);
    logic [8:0] r;
    unique case (a) inside
      8'h04:         r = {1'b1, (b & CMD_KEEP) | CMD_FIXED};
      8'h05, 8'h4f:  r = {1'b1, b & BIT0_MASK};
      8'h07:         r = {1'b1, (old & ~(b & STAT_W1C)) | STAT_FIXED};
      [8'h60:8'h63]: r = {1'b1, b & ROUTE_MASK};
      8'h6a:         r = {1'b1, b & TIMER_MASK};
      8'h80:         r = {1'b0, old};
      default:       r = {1'b1, b};
    endcase
    return r;
  endfunction

endpackage

>>> sv/pir_ctrl.sv
// Sequencer for the interrupt router: accept, route lookup, commit and result hold.
module pir_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  input  pir_pkg::req_e s_kind_i,
  input  logic          m_ready_i,
  output logic          s_ready_o,
  output logic          m_valid_o,
  output pir_pkg::cmd_t cmd_o
);
  import pir_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUTE,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   m_valid_q, m_valid_d;

  always_comb begin
    cmd_o.capture  = (state_q == ST_IDLE) && s_valid_i;
    cmd_o.share_rd = (state_q == ST_ROUTE);
    cmd_o.commit   = (state_q == ST_DONE) && (!m_valid_q || m_ready_i);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          state_d = (s_kind_i == REQ_LEVEL) ? ST_ROUTE : ST_DONE;
        end
      end
      ST_ROUTE: state_d = ST_DONE;
      ST_DONE: begin
        if (cmd_o.commit) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (cmd_o.commit) begin
      m_valid_d = 1'b1;
    end else if (m_ready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign s_ready_o = (state_q == ST_IDLE);
  assign m_valid_o = m_valid_q;

endmodule

>>> sv/pir_datapath.sv
// Datapath: byte-lane config store, sharing-word store, byte rules and result register.
module pir_datapath (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pir_pkg::cmd_t cmd_i,
  input  logic [1:0]    s_tuser_i,
  input  logic [63:0]   s_tdata_i,
  output logic [39:0]   m_tdata_o
);
  import pir_pkg::*;

  localparam logic [ROW_W-1:0] ROUTE_ROW = ROUTE_BASE[7:2];

  // input beat fields
  logic [11:0] in_off;
  logic [31:0] in_wdata;
  logic [2:0]  in_cnt;
  logic [4:0]  in_dev;
  logic [2:0]  in_pin;
  logic        in_level;
  req_e        in_kind;

  assign in_off   = s_tdata_i[11:0];
  assign in_wdata = s_tdata_i[43:12];
  assign in_cnt   = (s_tdata_i[46:44] > 3'd4) ? 3'd4 : s_tdata_i[46:44];
  assign in_dev   = s_tdata_i[54:50];
  assign in_pin   = s_tdata_i[57:55];
  assign in_level = s_tdata_i[58];
  assign in_kind  = req_e'(s_tuser_i);

  // captured item
  req_e               kind_q;
  logic [11:0]        off_q;
  logic [31:0]        wdata_q;
  logic [2:0]         cnt_q;
  logic [4:0]         dev_q;
  logic               level_q;
  logic [ROUTE_W-1:0] route_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q  <= in_kind;
      off_q   <= in_off;
      wdata_q <= in_wdata;
      cnt_q   <= in_cnt;
      dev_q   <= in_dev;
      level_q <= in_level;
      route_q <= in_dev[1:0] + in_pin[1:0] - ROUTE_W'(SLOT_BIAS);
    end
  end

  // address of the byte that falls in a lane, starting from offset off
  function automatic logic [12:0] lane_addr(input logic [11:0] off,
                                            input logic [LANE_W-1:0] lane);
    logic [LANE_W-1:0] idx;
    idx = lane - off[1:0];
    return {1'b0, off} + {11'b0, idx};
  endfunction

  logic [ROW_W-1:0] rd_row [LANES];
  logic [ROW_W-1:0] wr_row [LANES];
  logic [7:0]       wr_val [LANES];
  logic             wr_en  [LANES];
  logic [7:0]       rd_q   [LANES];
  logic             rd_vld_q [LANES];
  logic [7:0]       rd_def_q [LANES];
  logic [ROWS-1:0]  vld_q  [LANES];
  logic [7:0]       lane_byte [LANES];

  always_comb begin
    logic [12:0] a;
    for (int l = 0; l < LANES; l++) begin
      a = lane_addr(in_off, LANE_W'(l));
      rd_row[l] = (in_kind == REQ_LEVEL) ? ROUTE_ROW : a[7:2];
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [7:0] mem [ROWS];

    always_ff @(posedge clk_i) begin
      if (cmd_i.capture) begin
        rd_q[l]     <= mem[rd_row[l]];
        rd_def_q[l] <= cfg_default({rd_row[l], LANE_W'(l)});
      end
      if (wr_en[l]) begin
        mem[wr_row[l]] <= wr_val[l];
      end
    end

    // never-written bytes read as their power-on defaults
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[l]    <= '0;
        rd_vld_q[l] <= 1'b0;
      end else begin
        if (cmd_i.capture) begin
          rd_vld_q[l] <= vld_q[l][rd_row[l]];
        end
        if (wr_en[l]) begin
          vld_q[l][wr_row[l]] <= 1'b1;
        end
      end
    end

    assign lane_byte[l] = rd_vld_q[l] ? rd_q[l] : rd_def_q[l];
  end

  // config write and read
  logic        wr_open;
  logic [31:0] rd_data;

  assign wr_open = (kind_q == REQ_WRITE) &&
                   !(((off_q >= PROT_LO) && (off_q < PROT_HI)) || (off_q > LAST_BYTE[11:0]));

  always_comb begin
    logic [12:0]       a;
    logic [LANE_W-1:0] idx;
    logic [8:0]        rule;
    for (int l = 0; l < LANES; l++) begin
      idx  = LANE_W'(l) - off_q[1:0];
      a    = lane_addr(off_q, LANE_W'(l));
      rule = store_rule(a[7:0], wdata_q[8*idx +: 8], lane_byte[l]);
      wr_row[l] = a[7:2];
      wr_val[l] = rule[7:0];
      wr_en[l]  = cmd_i.commit && wr_open && ({1'b0, idx} < cnt_q) &&
                  (a <= LAST_BYTE) && rule[8];
    end
  end

  always_comb begin
    logic [12:0]       a;
    logic [LANE_W-1:0] lane;
    rd_data = '0;
    for (int i = 0; i < LANES; i++) begin
      a    = {1'b0, off_q} + 13'(i);
      lane = off_q[1:0] + LANE_W'(i);
      if ((kind_q == REQ_READ) && (3'(i) < cnt_q) && (a <= LAST_BYTE)) begin
        rd_data[8*i +: 8] = lane_byte[lane];
      end
    end
  end

  // route lookup and sharing words
  logic [7:0]         route_byte;
  logic [IRQ_W-1:0]   irq_q;
  logic               rt_en_q;
  logic [31:0]        sh_mem [ROUTE_COUNT * (1 << IRQ_W)];
  logic [31:0]        sh_rd_q;
  logic               sh_nz_rd_q;
  logic [ROUTE_COUNT * (1 << IRQ_W)-1:0] nz_q;
  logic [SHARE_W-1:0] sh_rd_addr;
  logic [SHARE_W-1:0] sh_addr;
  logic               sh_wr_en;
  logic [31:0]        sh_old;
  logic [31:0]        sh_new;
  logic               idle_pre;
  logic               idle_others;
  act_e               action;

  assign route_byte = lane_byte[route_q];
  assign sh_rd_addr = {route_q, route_byte[3:0]};
  assign sh_addr    = {route_q, irq_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.share_rd) begin
      irq_q   <= route_byte[3:0];
      rt_en_q <= !route_byte[7] && IRQ_ALLOWED[route_byte[3:0]];
      sh_rd_q <= sh_mem[sh_rd_addr];
    end
    if (sh_wr_en) begin
      sh_mem[sh_addr] <= sh_new;
    end
  end

  assign sh_wr_en = cmd_i.commit && (kind_q == REQ_LEVEL) && rt_en_q;
  assign sh_old   = sh_nz_rd_q ? sh_rd_q : '0;
  assign sh_new   = level_q ? (sh_old | (32'd1 << dev_q)) : (sh_old & ~(32'd1 << dev_q));

  always_comb begin
    idle_pre    = 1'b1;
    idle_others = 1'b1;
    for (int r = 0; r < ROUTE_COUNT; r++) begin
      if (nz_q[{ROUTE_W'(r), irq_q}]) begin
        idle_pre = 1'b0;
        if (ROUTE_W'(r) != route_q) begin
          idle_others = 1'b0;
        end
      end
    end
    action = ACT_NONE;
    if ((kind_q == REQ_LEVEL) && rt_en_q) begin
      if (level_q) begin
        action = idle_pre ? ACT_RAISE : ACT_NONE;
      end else begin
        action = (idle_others && (sh_new == '0)) ? ACT_LOWER : ACT_NONE;
      end
    end
  end

  // nonzero flags double as valid bits: a clear flag means an all-zero word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nz_q       <= '0;
      sh_nz_rd_q <= 1'b0;
    end else begin
      if (cmd_i.share_rd) begin
        sh_nz_rd_q <= nz_q[sh_rd_addr];
      end
      if (sh_wr_en) begin
        nz_q[sh_addr] <= |sh_new;
      end
    end
  end

  // result register
  logic [39:0] m_data_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      m_data_q <= {2'b00, (action == ACT_NONE) ? 4'd0 : irq_q, action, rd_data};
    end
  end

  assign m_tdata_o = m_data_q;

endmodule

>>> sv/pci_isa_interrupt_router_unit.sv
// PCI-to-ISA bridge config space with PCI interrupt routing to ISA IRQ lines.
// Each input beat is a config write, a config read or a device interrupt level
// change, and yields exactly one result beat. A config access first reads the
// four byte-lane banks of the 256-byte config store, then applies the byte
// rules, writes back and loads the result; for a level change, the route byte
// read from the config store selects the sharing word, which is read before
// it is updated in the write-back step. One item is in work
// at a time; the next beat is accepted as soon as the result sits in the
// output register, even if the sink has not taken it yet. No init pass after
// reset: never-written config bytes and sharing words read as their reset values.
module pci_isa_interrupt_router_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [11:0] cfg_offset, [43:12] write_data, [46:44] byte_count, [54:47] dev_func,
  // [57:55] int_pin, [58] int_level
  input  logic [63:0] s_axis_tdata,
  // [1:0] req_type
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] read_data, [33:32] pic_action, [37:34] pic_irq
  output logic [39:0] m_axis_tdata
);
  import pir_pkg::*;

  cmd_t cmd;

  pir_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_kind_i  (req_e'(s_axis_tuser)),
    .m_ready_i (m_axis_tready),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .cmd_o     (cmd)
  );

  pir_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .s_tuser_i (s_axis_tuser),
    .s_tdata_i (s_axis_tdata),
    .m_tdata_o (m_axis_tdata)
  );

  // a commit always leaves a result waiting
  a_commit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> m_axis_tvalid)
    else $error("result not presented after commit");

  // no result can appear in the cycle right after an accept
  a_accept_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !$rose(m_axis_tvalid))
    else $error("result appeared too early after accept");

  // route lookup and commit happen only with the input side closed
  a_busy_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.share_rd || cmd.commit) |-> !s_axis_tready)
    else $error("input open while an item is in work");

endmodule
